>>> hw/rtl/tccw_pkg.sv
// ----------------------------------------------------------------------------
// tccw_pkg: shared definitions for the text console character writer
// Holds the default geometry, character codes, blank cell value, controller
// state encoding and the command and status bundles between the controller
// and the datapath.
// ----------------------------------------------------------------------------
package tccw_pkg;

  // Default screen geometry.
  localparam int unsigned COLUMNS_DEF  = 80;
  localparam int unsigned ROWS_DEF     = 25;
  localparam int unsigned TAB_STOP_DEF = 8;

  // Fixed field widths of the ports.
  localparam int unsigned CHAR_W = 8;
  localparam int unsigned ATTR_W = 8;
  localparam int unsigned CELL_W = 16;
  localparam int unsigned OCOL_W = 7;
  localparam int unsigned OROW_W = 5;
  localparam int unsigned OLOC_W = 11;

  // Operation codes.
  localparam logic OP_PUT   = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  // Control characters.
  localparam logic [CHAR_W-1:0] CH_BS  = 8'h08;
  localparam logic [CHAR_W-1:0] CH_TAB = 8'h09;
  localparam logic [CHAR_W-1:0] CH_LF  = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_CR  = 8'h0D;

  // A blank cell is a space with bright white on black.
  localparam logic [CELL_W-1:0] BLANK_CELL = 16'h0F20;
  localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h0F;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_EXEC,
    ST_WALK,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic item_load;
    logic exec;
    logic walk_step;
    logic walk_fill;
    logic out_load;
  } ctl_cmd_t;

  typedef struct packed {
    logic is_clear;
    logic needs_scroll;
    logic walk_last;
  } dp_status_t;

endpackage

>>> hw/rtl/tccw_ctrl.sv
// ----------------------------------------------------------------------------
// tccw_ctrl: sequencing controller
// Runs the reset clearing pass, takes one transaction at a time, starts the
// clear or scroll walks and owns the result valid flag.
// ----------------------------------------------------------------------------
module tccw_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output tccw_pkg::ctl_cmd_t   cmd_o,
  input  tccw_pkg::dp_status_t status_i
);
  import tccw_pkg::*;

  state_e   state_q, state_d;
  logic     out_valid_q, out_valid_d;
  logic     fill_q, fill_d;
  logic     out_free;
  logic     needs_walk;
  ctl_cmd_t cmd;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign needs_walk = status_i.is_clear || status_i.needs_scroll;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_INIT: begin
        if (status_i.walk_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_EXEC;
      end
      ST_EXEC: begin
        if (needs_walk) begin
          state_d = ST_WALK;
        end else if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      ST_WALK: begin
        if (status_i.walk_last) state_d = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_INIT;
    endcase
  end

  always_comb begin
    cmd        = '0;
    fill_d     = fill_q;
    in_stall_o = 1'b1;
    case (state_q)
      ST_INIT: begin
        cmd.walk_step = 1'b1;
        cmd.walk_fill = 1'b1;
      end
      ST_IDLE: begin
        in_stall_o     = 1'b0;
        cmd.item_load  = in_valid_i;
      end
      ST_EXEC: begin
        if (needs_walk) begin
          cmd.exec = 1'b1;
          fill_d   = status_i.is_clear;
        end else if (out_free) begin
          cmd.exec     = 1'b1;
          cmd.out_load = 1'b1;
        end
      end
      ST_WALK: begin
        cmd.walk_step = 1'b1;
        cmd.walk_fill = fill_q;
      end
      ST_DONE: begin
        cmd.out_load = out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  assign out_valid_d = cmd.out_load ? 1'b1 : (out_valid_q && out_stall_i);
  assign out_valid_o = out_valid_q;
  assign cmd_o       = cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      out_valid_q <= 1'b0;
      fill_q      <= 1'b1;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      fill_q      <= fill_d;
    end
  end

`ifndef ASSERT_OFF
  // A result is only loaded when the output register is free.
  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> (!out_valid_q || !out_stall_i))
    else $error("result loaded over a pending result");

  // The cursor is committed once per item.
  a_exec_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.exec |=> !cmd.exec)
    else $error("item executed twice");

  // A walk is only entered for a clear or a scroll.
  a_walk_reason: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EXEC && state_d == ST_WALK) |-> needs_walk && cmd.exec)
    else $error("walk started without clear or scroll");
`endif

endmodule

>>> hw/rtl/tccw_datapath.sv
// ----------------------------------------------------------------------------
// tccw_datapath: cursor, attribute register, cell store and result register
// Computes the next cursor position for a held item, writes printable cells
// and carries out the clear and scroll walks over the cell store.
// ----------------------------------------------------------------------------
module tccw_datapath #(
  parameter int unsigned COLUMNS  = tccw_pkg::COLUMNS_DEF,
  parameter int unsigned ROWS     = tccw_pkg::ROWS_DEF,
  parameter int unsigned TAB_STOP = tccw_pkg::TAB_STOP_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  tccw_pkg::ctl_cmd_t            cmd_i,
  output tccw_pkg::dp_status_t          status_o,
  input  logic                          cfg_we_i,
  input  logic [tccw_pkg::ATTR_W-1:0]   cfg_data_i,
  input  logic                          op_i,
  input  logic [tccw_pkg::CHAR_W-1:0]   char_code_i,
  output logic [tccw_pkg::OCOL_W-1:0]   cursor_column_o,
  output logic [tccw_pkg::OROW_W-1:0]   cursor_row_out_o,
  output logic [tccw_pkg::OLOC_W-1:0]   cursor_location_o,
  output logic                          scrolled_o
);
  import tccw_pkg::*;

  localparam int unsigned CELLS = COLUMNS * ROWS;
  localparam int unsigned AW    = $clog2(CELLS);
  localparam int unsigned CW    = $clog2(COLUMNS);
  localparam int unsigned RW    = $clog2(ROWS);
  localparam int unsigned PW    = $clog2(TAB_STOP);
  localparam int unsigned CTW   = $clog2(COLUMNS + TAB_STOP);
  localparam int unsigned RTW   = $clog2(ROWS + 1);

  localparam logic [AW-1:0] COLS_A = AW'(COLUMNS);

  // Held item and architectural state.
  logic              item_op_q;
  logic [CHAR_W-1:0] item_char_q;
  logic [ATTR_W-1:0] attr_q;
  logic [CW-1:0]     col_q, col_d;
  logic [RW-1:0]     row_q, row_d;
  logic [PW-1:0]     phase_q, phase_d;
  logic              scroll_q, scroll_d;

  // Walk pipeline.
  logic [AW-1:0]     walk_q;
  logic [AW:0]       src_addr;
  logic              src_ok;
  logic              wr_pend_q;
  logic [AW-1:0]     wr_addr_q;
  logic              wr_blank_q;
  logic [CELL_W-1:0] rd_q;

  logic [CELL_W-1:0] mem [CELLS];

  // Next cursor computation.
  logic              printable;
  logic              put_we;
  logic [AW-1:0]     put_idx;
  logic [CTW-1:0]    col_a;
  logic [RTW-1:0]    row_a;
  logic [PW-1:0]     phase_a;

  // Result sources.
  logic [CW-1:0]     src_col;
  logic [RW-1:0]     src_row;
  logic              src_scroll;
  logic [AW-1:0]     src_loc;

  assign printable = (item_char_q[7:5] != 3'b000) && !item_char_q[7];
  assign put_idx   = AW'(row_q) * COLS_A + AW'(col_q);
  assign put_we    = cmd_i.exec && (item_op_q == OP_PUT) && printable;

  always_comb begin
    col_a   = CTW'(col_q);
    row_a   = RTW'(row_q);
    phase_a = phase_q;
    if (item_char_q == CH_BS) begin
      if (col_q != '0) begin
        col_a   = CTW'(col_q) - CTW'(1);
        phase_a = (phase_q == '0) ? PW'(TAB_STOP - 1) : phase_q - PW'(1);
      end
    end else if (item_char_q == CH_TAB) begin
      col_a   = CTW'(col_q) + CTW'(TAB_STOP) - CTW'(phase_q);
      phase_a = '0;
    end else if (item_char_q == CH_CR) begin
      col_a   = '0;
      phase_a = '0;
    end else if (item_char_q == CH_LF) begin
      col_a   = '0;
      row_a   = RTW'(row_q) + RTW'(1);
      phase_a = '0;
    end else if (printable) begin
      col_a   = CTW'(col_q) + CTW'(1);
      phase_a = (phase_q == PW'(TAB_STOP - 1)) ? '0 : phase_q + PW'(1);
    end

    if (col_a >= CTW'(COLUMNS)) begin
      col_a   = '0;
      row_a   = row_a + RTW'(1);
      phase_a = '0;
    end

    scroll_d = 1'b0;
    if (row_a >= RTW'(ROWS)) begin
      row_a    = RTW'(ROWS - 1);
      scroll_d = 1'b1;
    end

    col_d   = CW'(col_a);
    row_d   = RW'(row_a);
    phase_d = phase_a;

    if (item_op_q == OP_CLEAR) begin
      col_d    = '0;
      row_d    = '0;
      phase_d  = '0;
      scroll_d = 1'b0;
    end
  end

  assign status_o.is_clear     = (item_op_q == OP_CLEAR);
  assign status_o.needs_scroll = scroll_d;
  assign status_o.walk_last    = (walk_q == AW'(CELLS - 1));

  // During a walk the result source is the committed cursor; while an item is
  // being executed it is the freshly computed one.
  assign src_col    = cmd_i.exec ? col_d    : col_q;
  assign src_row    = cmd_i.exec ? row_d    : row_q;
  assign src_scroll = cmd_i.exec ? scroll_d : scroll_q;
  assign src_loc    = AW'(src_row) * COLS_A + AW'(src_col);

  assign src_addr = {1'b0, walk_q} + (AW + 1)'(COLUMNS);
  assign src_ok   = src_addr < (AW + 1)'(CELLS);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q     <= '0;
      row_q     <= '0;
      phase_q   <= '0;
      attr_q    <= ATTR_RESET;
      walk_q    <= '0;
      wr_pend_q <= 1'b0;
    end else begin
      if (cfg_we_i) attr_q <= cfg_data_i;
      if (cmd_i.exec) begin
        col_q   <= col_d;
        row_q   <= row_d;
        phase_q <= phase_d;
      end
      if (cmd_i.walk_step) begin
        walk_q <= status_o.walk_last ? '0 : walk_q + AW'(1);
      end
      wr_pend_q <= cmd_i.walk_step;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.item_load) begin
      item_op_q   <= op_i;
      item_char_q <= char_code_i;
    end
    if (cmd_i.exec) scroll_q <= scroll_d;
    wr_addr_q  <= walk_q;
    wr_blank_q <= cmd_i.walk_fill || !src_ok;
    if (cmd_i.out_load) begin
      cursor_column_o   <= OCOL_W'(src_col);
      cursor_row_out_o  <= OROW_W'(src_row);
      cursor_location_o <= OLOC_W'(src_loc);
      scrolled_o        <= src_scroll;
    end
  end

  // Cell store: one write port shared by the walk and printable writes, one
  // registered read port used by the scroll copy.
  always_ff @(posedge clk_i) begin
    if (cmd_i.walk_step && !cmd_i.walk_fill && src_ok) begin
      rd_q <= mem[src_addr[AW-1:0]];
    end
    if (wr_pend_q) begin
      mem[wr_addr_q] <= wr_blank_q ? BLANK_CELL : rd_q;
    end else if (put_we) begin
      mem[put_idx] <= {attr_q, item_char_q};
    end
  end

`ifndef ASSERT_OFF
  // The stored cursor always lies on the screen.
  a_cursor_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (CTW'(col_q) < CTW'(COLUMNS)) && (RTW'(row_q) < RTW'(ROWS)))
    else $error("cursor off screen");

  // A walk write never collides with a printable write.
  a_write_port: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_pend_q |-> !put_we)
    else $error("cell store write collision");

  // The walk counter rests at zero between walks.
  a_walk_rest: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cmd_i.walk_step |-> (walk_q == '0))
    else $error("walk counter not at rest");
`endif

endmodule

>>> hw/rtl/text_console_char_writer.sv
// ----------------------------------------------------------------------------
// text_console_char_writer: text-mode console character engine
// Keeps a screen of character cells and a cursor, interprets put and clear
// transactions and reports the cursor position after each one.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid_i / in_stall_o) carries one transaction per
//   op_i / char_code_i pair. The output channel (out_valid_o / out_stall_i)
//   returns exactly one result per transaction: the cursor column, row,
//   linear location and a flag telling whether the screen scrolled.
//   The attribute used for printable characters is written through
//   cfg_we_i / cfg_data_i and should only change while the block is idle.
//   A put that does not scroll is accepted in the idle state; the execute
//   state then commits the cursor, writes a printable cell and loads the
//   result register once that register is free.
//   A clear, or a put that scrolls, walks the whole cell store through its
//   single write port before its result is loaded.
//   After reset the block blanks the store in a clearing pass and stalls
//   input meanwhile.
//   A stalled result waits in the output register; the next transaction is
//   still accepted; its result is loaded once that register frees up.
// ----------------------------------------------------------------------------
module text_console_char_writer #(
  parameter int unsigned COLUMNS  = tccw_pkg::COLUMNS_DEF,
  parameter int unsigned ROWS     = tccw_pkg::ROWS_DEF,
  parameter int unsigned TAB_STOP = tccw_pkg::TAB_STOP_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [tccw_pkg::ATTR_W-1:0] cfg_data_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        op_i,
  input  logic [tccw_pkg::CHAR_W-1:0] char_code_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [tccw_pkg::OCOL_W-1:0] cursor_column_o,
  output logic [tccw_pkg::OROW_W-1:0] cursor_row_out_o,
  output logic [tccw_pkg::OLOC_W-1:0] cursor_location_o,
  output logic                        scrolled_o
);
  import tccw_pkg::*;

  // Command and status bundles between the sequencer and the datapath.
  ctl_cmd_t   cmd;
  dp_status_t status;

  // The controller decides when a transaction is taken, when the cursor is
  // committed, when a walk runs and when the result register is loaded.
  tccw_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd),
    .status_i    (status)
  );

  // The datapath holds the cursor, the attribute register, the cell store
  // and the result payload.
  tccw_datapath #(
    .COLUMNS  (COLUMNS),
    .ROWS     (ROWS),
    .TAB_STOP (TAB_STOP)
  ) u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .status_o          (status),
    .cfg_we_i          (cfg_we_i),
    .cfg_data_i        (cfg_data_i),
    .op_i              (op_i),
    .char_code_i       (char_code_i),
    .cursor_column_o   (cursor_column_o),
    .cursor_row_out_o  (cursor_row_out_o),
    .cursor_location_o (cursor_location_o),
    .scrolled_o        (scrolled_o)
  );

endmodule

>>> tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for text_console_char_writer
// Drives put and clear transactions through the valid/stall input channel,
// keeps a cycle-free prediction of the cursor and screen store, and checks
// every reported cursor position and scroll flag in order.
// ----------------------------------------------------------------------------
module testbench;
  import tccw_pkg::*;

  localparam int unsigned COLS       = COLUMNS_DEF;
  localparam int unsigned ROWS       = ROWS_DEF;
  localparam int unsigned TAB        = TAB_STOP_DEF;
  localparam int unsigned CELL_COUNT = COLS * ROWS;

  // Printable range of a put transaction.
  localparam logic [CHAR_W-1:0] PRINT_FIRST = 8'h20;
  localparam logic [CHAR_W-1:0] PRINT_LAST  = 8'h7F;

  // Random part: five phases of this many transactions each.
  localparam int unsigned PHASE_COUNT = 5;
  localparam int unsigned PHASE_ITEMS = 80;

  // A scroll or clear walks the whole store, so quiet time at the end has
  // to cover one full walk and the control states around it.
  localparam int unsigned SETTLE_CYCLES = CELL_COUNT + 16;

  typedef struct packed {
    logic [OCOL_W-1:0] col;
    logic [OROW_W-1:0] row;
    logic [OLOC_W-1:0] loc;
    logic              scrolled;
  } cursor_report_t;

  // --------------------------------------------------------------------------
  // Console scoreboard. It mirrors the cursor, the attribute register and the
  // cell store, and queues the cursor report each accepted transaction must
  // produce. Only the reports are visible at the ports, but the store is
  // kept so that the prediction follows the block's full behavior.
  // --------------------------------------------------------------------------
  class console_scoreboard;
    bit [CELL_W-1:0] cells [CELL_COUNT];
    int unsigned     cur_col;
    int unsigned     cur_row;
    bit [ATTR_W-1:0] attr;
    cursor_report_t  reports_due[$];
    int unsigned     mismatches;

    function void blank_from(int unsigned first);
      for (int unsigned i = first; i < CELL_COUNT; i++) cells[i] = BLANK_CELL;
    endfunction

    function void power_on();
      blank_from(0);
      cur_col    = 0;
      cur_row    = 0;
      attr       = ATTR_RESET;
      mismatches = 0;
      reports_due.delete();
    endfunction

    // Applies one accepted transaction and queues the cursor report it owes.
    function void note_item(logic op, logic [CHAR_W-1:0] ch);
      int unsigned    c;
      int unsigned    r;
      bit             scroll_up;
      cursor_report_t rep;
      c         = cur_col;
      r         = cur_row;
      scroll_up = 1'b0;
      if (op == OP_CLEAR) begin
        blank_from(0);
        c = 0;
        r = 0;
      end else begin
        case (ch)
          CH_BS: begin
            if (c != 0) c--;
          end
          CH_TAB: c = c + TAB - (c % TAB);
          CH_CR:  c = 0;
          CH_LF: begin
            c = 0;
            r++;
          end
          default: begin
            // Anything outside the printable range leaves the cursor alone.
            if (ch >= PRINT_FIRST && ch <= PRINT_LAST) begin
              cells[r * COLS + c] = {attr, ch};
              c++;
            end
          end
        endcase
        if (c >= COLS) begin
          c = 0;
          r++;
        end
        if (r >= ROWS) begin
          for (int unsigned i = 0; i < CELL_COUNT - COLS; i++) cells[i] = cells[i + COLS];
          blank_from(CELL_COUNT - COLS);
          r         = ROWS - 1;
          scroll_up = 1'b1;
        end
      end
      cur_col      = c;
      cur_row      = r;
      rep.col      = OCOL_W'(c);
      rep.row      = OROW_W'(r);
      rep.loc      = OLOC_W'(r * COLS + c);
      rep.scrolled = scroll_up;
      reports_due.push_back(rep);
    endfunction

    task flag_mismatch(string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      mismatches++;
    endtask

    task check_report(cursor_report_t got);
      cursor_report_t want;
      if (reports_due.size() == 0) begin
        flag_mismatch($sformatf("unexpected report col=%0d row=%0d loc=%0d scrolled=%0d",
                                got.col, got.row, got.loc, got.scrolled));
        return;
      end
      want = reports_due.pop_front();
      if (got.col !== want.col)
        flag_mismatch($sformatf("cursor_column %0d, expected %0d", got.col, want.col));
      if (got.row !== want.row)
        flag_mismatch($sformatf("cursor_row_out %0d, expected %0d", got.row, want.row));
      if (got.loc !== want.loc)
        flag_mismatch($sformatf("cursor_location %0d, expected %0d", got.loc, want.loc));
      if (got.scrolled !== want.scrolled)
        flag_mismatch($sformatf("scrolled %0d, expected %0d", got.scrolled, want.scrolled));
    endtask
  endclass

  // Every input of the block starts at a known value.
  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               cfg_we_i    = 1'b0;
  logic [ATTR_W-1:0]  cfg_data_i  = '0;
  logic               in_valid_i  = 1'b0;
  logic               op_i        = OP_PUT;
  logic [CHAR_W-1:0]  char_code_i = '0;
  logic               out_stall_i = 1'b0;
  logic               in_stall_o;
  logic               out_valid_o;
  logic [OCOL_W-1:0]  cursor_column_o;
  logic [OROW_W-1:0]  cursor_row_out_o;
  logic [OLOC_W-1:0]  cursor_location_o;
  logic               scrolled_o;
  cursor_report_t     observed;

  console_scoreboard  sb;
  int unsigned        send_gap_pct   = 0;
  int unsigned        recv_stall_pct = 0;

  text_console_char_writer #(
    .COLUMNS  (COLS),
    .ROWS     (ROWS),
    .TAB_STOP (TAB)
  ) dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_data_i        (cfg_data_i),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .op_i              (op_i),
    .char_code_i       (char_code_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .cursor_column_o   (cursor_column_o),
    .cursor_row_out_o  (cursor_row_out_o),
    .cursor_location_o (cursor_location_o),
    .scrolled_o        (scrolled_o)
  );

  assign observed = {cursor_column_o, cursor_row_out_o, cursor_location_o, scrolled_o};

  always #4 clk_i = ~clk_i;

  // Result side. Values read right after the edge are the ones the block saw
  // at that edge, since every driver here uses nonblocking assignments. A
  // transaction completes when valid is high and our stall was low; the stall
  // for the next edge is then drawn from the current phase's percentage.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_report(observed);
    out_stall_i <= ($urandom_range(99) < recv_stall_pct);
  end

  // Offers one transaction and holds it until the block takes it. Valid stays
  // high after acceptance unless a gap is drawn, so back-to-back transactions
  // never drop valid between them; callers that stop sending lower it.
  task automatic send_item(logic op, logic [CHAR_W-1:0] ch);
    op_i        <= op;
    char_code_i <= ch;
    in_valid_i  <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_item(op, ch);
    if ($urandom_range(99) < send_gap_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_gap_pct);
    end
  endtask

  // Stops offering input and waits until every queued report has come back.
  // Each transaction owes exactly one report, so an empty queue means idle.
  task automatic drain_reports();
    in_valid_i <= 1'b0;
    while (sb.reports_due.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_attribute(logic [ATTR_W-1:0] value);
    cfg_we_i   <= 1'b1;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    sb.attr = value;
  endtask

  // Random transaction mix. Line feeds are frequent so the cursor reaches the
  // bottom row and scrolls often; clears are rare because each one walks the
  // whole store and would keep sending the cursor home. A slice of fully
  // random bytes makes every bit of the character take both values.
  function automatic void pick_item(output logic op, output logic [CHAR_W-1:0] ch);
    int unsigned roll;
    roll = $urandom_range(999);
    op   = OP_PUT;
    ch   = CHAR_W'($urandom_range(PRINT_FIRST, PRINT_LAST));
    if (roll < 5) begin
      op = OP_CLEAR;
      ch = CHAR_W'($urandom_range(255));
    end else if (roll < 165) begin
      ch = CH_LF;
    end else if (roll < 215) begin
      ch = CH_TAB;
    end else if (roll < 255) begin
      ch = CH_BS;
    end else if (roll < 285) begin
      ch = CH_CR;
    end else if (roll < 365) begin
      ch = CHAR_W'($urandom_range(255));
    end else if (roll < 400) begin
      ch = CHAR_W'($urandom_range(8'h80, 8'hFF));
    end
  endfunction

  initial begin
    logic              rand_op;
    logic [CHAR_W-1:0] rand_ch;

    sb = new;
    sb.power_on();

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // The block runs its clearing pass after reset and stalls input until it
    // is done, so the first transaction simply waits on the handshake.
    write_attribute(8'h00);

    // Directed part, with no idling on either side.
    send_item(OP_PUT, 8'h41);
    send_item(OP_PUT, CH_BS);
    // Backspace at column 0 must leave the cursor where it is.
    send_item(OP_PUT, CH_BS);
    send_item(OP_PUT, CH_TAB);
    send_item(OP_PUT, PRINT_FIRST);
    send_item(OP_PUT, PRINT_LAST);
    // Tab from a column that is not on a stop.
    send_item(OP_PUT, CH_TAB);
    send_item(OP_PUT, CH_CR);
    send_item(OP_PUT, CH_LF);
    // Ignored bytes: low control codes without a meaning and the upper half.
    send_item(OP_PUT, 8'h00);
    send_item(OP_PUT, 8'h1F);
    send_item(OP_PUT, 8'h0B);
    send_item(OP_PUT, 8'h80);
    send_item(OP_PUT, 8'hFF);
    // Clear carries a byte that must be ignored.
    send_item(OP_CLEAR, 8'hFF);
    // Ten tabs from home: the last one runs past the final column and wraps.
    repeat (10) send_item(OP_PUT, CH_TAB);
    drain_reports();

    for (int unsigned phase = 0; phase < PHASE_COUNT; phase++) begin
      case (phase)
        0: begin
          send_gap_pct   = 0;
          recv_stall_pct = 0;
          write_attribute(8'hFF);
        end
        1: begin
          send_gap_pct   = 69;
          recv_stall_pct = 0;
          write_attribute(ATTR_W'($urandom_range(255)));
        end
        2: begin
          send_gap_pct   = 0;
          recv_stall_pct = 69;
          write_attribute(8'h80);
        end
        3: begin
          send_gap_pct   = 27;
          recv_stall_pct = 27;
          write_attribute(ATTR_W'($urandom_range(255)));
        end
        default: begin
          send_gap_pct   = 0;
          recv_stall_pct = 0;
          write_attribute(ATTR_RESET);
        end
      endcase
      for (int unsigned n = 0; n < PHASE_ITEMS; n++) begin
        pick_item(rand_op, rand_ch);
        send_item(rand_op, rand_ch);
        // Now and then the sender holds off until the block has caught up.
        if ($urandom_range(49) == 0) drain_reports();
      end
      drain_reports();
    end

    recv_stall_pct = 0;
    drain_reports();
    // Any stray report would come out of a store walk at the latest.
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    if (sb.mismatches == 0 && sb.reports_due.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Watchdog, far beyond a run where every transaction walks the store.
  initial begin
    #(40_000_000);
    $display("TB_ERROR");
    $finish;
  end

endmodule
